// ===== rtl/boundary_tag_first_fit_allocator_assert.svh =====
// assertion macros for the boundary tag allocator checker
// no dependencies; included by the checker file
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BTFF_AST_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BTFF_AST_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/btff_pkg.sv =====
// shared types and constants of the boundary tag first-fit allocator
// no dependencies
`timescale 1ns / 1ps

package btff_pkg;

	localparam int unsigned TAG_BYTES     = 24;
	localparam int unsigned GRAN_SHIFT    = 4;
	localparam int unsigned MIN_SPLIT     = 3;
	localparam int unsigned ARENA_MIN     = 3;
	localparam int unsigned ARENA_RESET   = 4096;

	typedef enum logic [0:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERO    = 2'd1,
		ST_NOFIT   = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		W_ALLOC   = 2'd0,
		W_RM_NEXT = 2'd1,
		W_RM_PREV = 2'd2
	} walk_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_SEED,
		S_IDLE,
		S_WRD,
		S_WCHK,
		S_UNL,
		S_AWR1,
		S_AWR2,
		S_FHDR,
		S_FNRD,
		S_FNCHK,
		S_NMRG,
		S_NMRG2,
		S_FPRD,
		S_FPCHK,
		S_PMRG,
		S_PMRG2,
		S_FPUSH,
		S_FIN
	} state_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] req_bytes;
		logic [15:0] release_offset;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] payload_offset;
		logic [15:0] inuse_bytes;
		logic [11:0] live_blocks;
		logic [11:0] free_blocks;
	} rsp_t;

endpackage

// ===== rtl/btff_ram.sv =====
// simple dual-port tag memory, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module btff_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/boundary_tag_first_fit_allocator.sv =====
// allocate walks the free list through header memory for the first block that fits;
// free merges with free neighbors, walking the free list for up to two list unlinks
// one transaction at a time; a new start is taken only while busy is low
// reset and each cfg_we arena size write run a clearing pass over every header with busy
// high; counters and free list then hold one free block spanning the arena
// done pulses for one cycle with the result; the receiver cannot stall
`timescale 1ns / 1ps

module boundary_tag_first_fit_allocator #(
	parameter int ARENA_GRANULES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  btff_pkg::req_t   request,
	output logic             done,
	output btff_pkg::rsp_t   result,
	input  logic             cfg_we,
	input  logic [12:0]      cfg_wdata
);

	localparam int AW = $clog2(ARENA_GRANULES);
	localparam int SW = $clog2(ARENA_GRANULES + 1);
	localparam int CW = (SW > 13) ? SW : 13;
	localparam int XW = CW + 1;
	localparam int BW = SW + 4;
	localparam logic [XW-1:0] AG_X = XW'(ARENA_GRANULES);
	localparam logic [SW-1:0] ARENA_RST =
		SW'((ARENA_GRANULES < btff_pkg::ARENA_RESET) ? ARENA_GRANULES : btff_pkg::ARENA_RESET);

	typedef struct packed {
		logic          start;
		logic          used;
		logic [SW-1:0] size;
		logic [AW-1:0] link;
	} hdr_t;

	typedef struct packed {
		logic          used;
		logic [SW-1:0] size;
	} ftr_t;

	btff_pkg::state_t state_q, state_d;

	// control registers
	logic [SW-1:0] arena_q;
	logic [AW-1:0] head_q;
	logic [SW-1:0] fcnt_q;
	logic [SW-1:0] live_q;
	logic [BW-1:0] bytes_q;
	logic [AW-1:0] clr_q;
	logic          done_q;

	// payload registers
	btff_pkg::status_t status_q;
	btff_pkg::walk_t   purp_q;
	logic [15:0]   off_q;
	logic [CW-1:0] need_q;
	logic [AW-1:0] b_q, n_q, p_q, cur_q, prev_q, tgt_q;
	logic [SW-1:0] sz_q, psz_q, k_q;
	hdr_t          bw_q, nw_q, pw_q, cw_q;

	// memory ports
	logic          hw_en, hr_en, fw_en, fr_en;
	logic [AW-1:0] hw_addr, hr_addr, fw_addr, fr_addr;
	hdr_t          hw_data, hdr_rd;
	ftr_t          fw_data, ftr_rd;

	btff_ram #(.DEPTH(ARENA_GRANULES), .WIDTH($bits(hdr_t))) u_hdr_ram (
		.clk   (clk),
		.we    (hw_en),
		.waddr (hw_addr),
		.wdata (hw_data),
		.re    (hr_en),
		.raddr (hr_addr),
		.rdata (hdr_rd)
	);

	btff_ram #(.DEPTH(ARENA_GRANULES), .WIDTH($bits(ftr_t))) u_ftr_ram (
		.clk   (clk),
		.we    (fw_en),
		.waddr (fw_addr),
		.wdata (fw_data),
		.re    (fr_en),
		.raddr (fr_addr),
		.rdata (ftr_rd)
	);

	// request decode
	logic [16:0]   req_rnd;
	logic [CW-1:0] need_calc;
	logic [11:0]   b12;
	logic          free_bad;
	logic [SW-1:0] cfg_clamped;

	assign req_rnd   = {1'b0, request.req_bytes} + 17'd15;
	assign need_calc = CW'(req_rnd[16:4]) + CW'(2);
	assign b12       = request.release_offset[15:4] - 12'd1;
	assign free_bad  = (request.release_offset < 16'd16)
		|| (request.release_offset[3:0] != 4'd0)
		|| (32'(request.release_offset) >= (32'(arena_q) << btff_pkg::GRAN_SHIFT))
		|| (32'(b12) >= 32'(ARENA_GRANULES));
	assign cfg_clamped = (32'(cfg_wdata) < 32'(btff_pkg::ARENA_MIN)) ? SW'(btff_pkg::ARENA_MIN) :
		(32'(cfg_wdata) > 32'(ARENA_GRANULES)) ? SW'(ARENA_GRANULES) : SW'(cfg_wdata);

	// walk
	logic walk_more, hit;
	assign walk_more = (k_q < fcnt_q) && (XW'(cur_q) < AG_X);
	assign hit = (purp_q == btff_pkg::W_ALLOC) ? (XW'(hdr_rd.size) >= XW'(need_q))
		: (cur_q == tgt_q);

	// allocate split
	logic [XW-1:0] have_x, need_x, rem_x, e1_x, e2_x;
	logic          split;
	logic [SW-1:0] fin_sz;
	logic [AW-1:0] a2;
	logic [XW+3:0] off_calc;
	assign have_x   = XW'(cw_q.size);
	assign need_x   = XW'(need_q);
	assign rem_x    = have_x - need_x;
	assign split    = (rem_x >= XW'(btff_pkg::MIN_SPLIT)) && ((XW'(cur_q) + need_x) < AG_X);
	assign fin_sz   = split ? SW'(need_q) : cw_q.size;
	assign e1_x     = XW'(cur_q) + XW'(fin_sz) - XW'(1);
	assign e2_x     = XW'(cur_q) + have_x - XW'(1);
	assign a2       = AW'(XW'(cur_q) + need_x);
	assign off_calc = ((XW+4)'(cur_q) + (XW+4)'(1)) << btff_pkg::GRAN_SHIFT;

	// free
	logic [XW-1:0] fh_e_x, fh_n_x, e3_x, e4_x;
	logic          n_ok, nchk, pchk;
	logic [SW-1:0] tot;
	assign fh_e_x = XW'(b_q) + XW'(hdr_rd.size) - XW'(1);
	assign fh_n_x = XW'(b_q) + XW'(hdr_rd.size);
	assign n_ok   = (fh_n_x < XW'(arena_q)) && (fh_n_x < AG_X);
	assign nchk   = hdr_rd.start && !hdr_rd.used
		&& (XW'(hdr_rd.size) <= (XW'(arena_q) - XW'(n_q)));
	assign pchk   = !ftr_rd.used && (ftr_rd.size != '0) && (XW'(ftr_rd.size) <= XW'(b_q));
	assign e3_x   = XW'(b_q) + XW'(sz_q) - XW'(1);
	assign tot    = psz_q + sz_q;
	assign e4_x   = XW'(p_q) + XW'(tot) - XW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btff_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		hw_en   = 1'b0;
		hw_addr = b_q;
		hw_data = bw_q;
		hr_en   = 1'b0;
		hr_addr = cur_q;
		fw_en   = 1'b0;
		fw_addr = b_q;
		fw_data = '{used: 1'b0, size: sz_q};
		fr_en   = 1'b0;
		fr_addr = b_q - AW'(1);
		case (state_q)
			btff_pkg::S_CLR: begin
				hw_en   = 1'b1;
				hw_addr = clr_q;
				hw_data = '0;
				if (clr_q == AW'(ARENA_GRANULES - 1)) begin
					state_d = btff_pkg::S_SEED;
				end
			end
			btff_pkg::S_SEED: begin
				hw_en   = 1'b1;
				hw_addr = '0;
				hw_data = '{start: 1'b1, used: 1'b0, size: arena_q, link: '0};
				fw_en   = 1'b1;
				fw_addr = AW'(arena_q - SW'(1));
				fw_data = '{used: 1'b0, size: arena_q};
				state_d = btff_pkg::S_IDLE;
			end
			btff_pkg::S_IDLE: begin
				if (start) begin
					if (request.cmd == btff_pkg::CMD_FREE) begin
						if (free_bad) begin
							state_d = btff_pkg::S_FIN;
						end else begin
							hr_en   = 1'b1;
							hr_addr = AW'(b12);
							state_d = btff_pkg::S_FHDR;
						end
					end else if (request.req_bytes == 16'd0) begin
						state_d = btff_pkg::S_FIN;
					end else begin
						state_d = btff_pkg::S_WRD;
					end
				end
			end
			btff_pkg::S_WRD: begin
				if (walk_more) begin
					hr_en   = 1'b1;
					state_d = btff_pkg::S_WCHK;
				end else begin
					case (purp_q)
						btff_pkg::W_RM_NEXT: state_d = btff_pkg::S_NMRG;
						btff_pkg::W_RM_PREV: state_d = btff_pkg::S_PMRG;
						default:             state_d = btff_pkg::S_FIN;
					endcase
				end
			end
			btff_pkg::S_WCHK: begin
				state_d = hit ? btff_pkg::S_UNL : btff_pkg::S_WRD;
			end
			btff_pkg::S_UNL: begin
				if (k_q != '0) begin
					hw_en   = 1'b1;
					hw_addr = prev_q;
					hw_data = '{start: pw_q.start, used: pw_q.used, size: pw_q.size,
						link: cw_q.link};
				end
				case (purp_q)
					btff_pkg::W_RM_NEXT: state_d = btff_pkg::S_NMRG;
					btff_pkg::W_RM_PREV: state_d = btff_pkg::S_PMRG;
					default:             state_d = btff_pkg::S_AWR1;
				endcase
			end
			btff_pkg::S_AWR1: begin
				hw_en   = 1'b1;
				hw_addr = cur_q;
				hw_data = '{start: cw_q.start, used: 1'b1, size: fin_sz, link: cw_q.link};
				fw_en   = e1_x < AG_X;
				fw_addr = AW'(e1_x);
				fw_data = '{used: 1'b1, size: fin_sz};
				state_d = split ? btff_pkg::S_AWR2 : btff_pkg::S_FIN;
			end
			btff_pkg::S_AWR2: begin
				hw_en   = 1'b1;
				hw_addr = a2;
				hw_data = '{start: 1'b1, used: 1'b0, size: SW'(rem_x), link: head_q};
				fw_en   = e2_x < AG_X;
				fw_addr = AW'(e2_x);
				fw_data = '{used: 1'b0, size: SW'(rem_x)};
				state_d = btff_pkg::S_FIN;
			end
			btff_pkg::S_FHDR: begin
				if (!(hdr_rd.start && hdr_rd.used)) begin
					state_d = btff_pkg::S_FIN;
				end else begin
					hw_en   = 1'b1;
					hw_addr = b_q;
					hw_data = '{start: hdr_rd.start, used: 1'b0, size: hdr_rd.size,
						link: hdr_rd.link};
					fw_en   = fh_e_x < AG_X;
					fw_addr = AW'(fh_e_x);
					fw_data = '{used: 1'b0, size: hdr_rd.size};
					state_d = n_ok ? btff_pkg::S_FNRD : btff_pkg::S_FPRD;
				end
			end
			btff_pkg::S_FNRD: begin
				hr_en   = 1'b1;
				hr_addr = n_q;
				state_d = btff_pkg::S_FNCHK;
			end
			btff_pkg::S_FNCHK: begin
				state_d = nchk ? btff_pkg::S_WRD : btff_pkg::S_FPRD;
			end
			btff_pkg::S_NMRG: begin
				// next neighbor stops being a block start
				hw_en   = 1'b1;
				hw_addr = n_q;
				hw_data = '{start: 1'b0, used: nw_q.used, size: nw_q.size, link: nw_q.link};
				state_d = btff_pkg::S_NMRG2;
			end
			btff_pkg::S_NMRG2: begin
				hw_en   = 1'b1;
				hw_addr = b_q;
				hw_data = bw_q;
				fw_en   = e3_x < AG_X;
				fw_addr = AW'(e3_x);
				fw_data = '{used: 1'b0, size: sz_q};
				state_d = btff_pkg::S_FPRD;
			end
			btff_pkg::S_FPRD: begin
				if (b_q != '0) begin
					fr_en   = 1'b1;
					state_d = btff_pkg::S_FPCHK;
				end else begin
					state_d = btff_pkg::S_FPUSH;
				end
			end
			btff_pkg::S_FPCHK: begin
				state_d = pchk ? btff_pkg::S_WRD : btff_pkg::S_FPUSH;
			end
			btff_pkg::S_PMRG: begin
				hw_en   = 1'b1;
				hw_addr = b_q;
				hw_data = '{start: 1'b0, used: bw_q.used, size: bw_q.size, link: bw_q.link};
				hr_en   = 1'b1;
				hr_addr = p_q;
				state_d = btff_pkg::S_PMRG2;
			end
			btff_pkg::S_PMRG2: begin
				hw_en   = 1'b1;
				hw_addr = p_q;
				hw_data = '{start: hdr_rd.start, used: 1'b0, size: tot, link: head_q};
				fw_en   = e4_x < AG_X;
				fw_addr = AW'(e4_x);
				fw_data = '{used: 1'b0, size: tot};
				state_d = btff_pkg::S_FIN;
			end
			btff_pkg::S_FPUSH: begin
				hw_en   = 1'b1;
				hw_addr = b_q;
				hw_data = '{start: bw_q.start, used: bw_q.used, size: bw_q.size, link: head_q};
				state_d = btff_pkg::S_FIN;
			end
			btff_pkg::S_FIN: begin
				state_d = btff_pkg::S_IDLE;
			end
			default: begin
				state_d = btff_pkg::S_IDLE;
			end
		endcase
		if (cfg_we) begin
			state_d = btff_pkg::S_CLR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q <= ARENA_RST;
			head_q  <= '0;
			fcnt_q  <= SW'(1);
			live_q  <= '0;
			bytes_q <= '0;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == btff_pkg::S_FIN);
			case (state_q)
				btff_pkg::S_CLR: clr_q <= clr_q + AW'(1);
				btff_pkg::S_SEED: begin
					head_q  <= '0;
					fcnt_q  <= SW'(1);
					live_q  <= '0;
					bytes_q <= '0;
				end
				btff_pkg::S_UNL: begin
					if (k_q == '0) begin
						head_q <= cw_q.link;
					end
					fcnt_q <= fcnt_q - SW'(1);
				end
				btff_pkg::S_AWR1: begin
					bytes_q <= bytes_q + (BW'(fin_sz) << btff_pkg::GRAN_SHIFT)
						- BW'(btff_pkg::TAG_BYTES);
					live_q  <= live_q + SW'(1);
				end
				btff_pkg::S_AWR2: begin
					head_q <= a2;
					fcnt_q <= fcnt_q + SW'(1);
				end
				btff_pkg::S_FHDR: begin
					if (hdr_rd.start && hdr_rd.used) begin
						bytes_q <= bytes_q - (BW'(hdr_rd.size) << btff_pkg::GRAN_SHIFT)
							+ BW'(btff_pkg::TAG_BYTES);
						live_q  <= live_q - SW'(1);
					end
				end
				btff_pkg::S_PMRG2: begin
					head_q <= p_q;
					fcnt_q <= fcnt_q + SW'(1);
				end
				btff_pkg::S_FPUSH: begin
					head_q <= b_q;
					fcnt_q <= fcnt_q + SW'(1);
				end
				default: begin
				end
			endcase
			if (cfg_we) begin
				arena_q <= cfg_clamped;
				clr_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			btff_pkg::S_IDLE: begin
				if (start) begin
					status_q <= btff_pkg::ST_OK;
					off_q    <= '0;
					need_q   <= need_calc;
					b_q      <= AW'(b12);
					cur_q    <= head_q;
					k_q      <= '0;
					purp_q   <= btff_pkg::W_ALLOC;
					if (request.cmd == btff_pkg::CMD_FREE) begin
						if (free_bad) begin
							status_q <= btff_pkg::ST_IGNORED;
						end
					end else if (request.req_bytes == 16'd0) begin
						status_q <= btff_pkg::ST_ZERO;
					end
				end
			end
			btff_pkg::S_WRD: begin
				if (!walk_more && purp_q == btff_pkg::W_ALLOC) begin
					status_q <= btff_pkg::ST_NOFIT;
				end
			end
			btff_pkg::S_WCHK: begin
				if (hit) begin
					cw_q <= hdr_rd;
				end else begin
					prev_q <= cur_q;
					pw_q   <= hdr_rd;
					cur_q  <= hdr_rd.link;
					k_q    <= k_q + SW'(1);
				end
			end
			btff_pkg::S_AWR1: begin
				off_q <= off_calc[15:0];
			end
			btff_pkg::S_FHDR: begin
				if (!(hdr_rd.start && hdr_rd.used)) begin
					status_q <= btff_pkg::ST_IGNORED;
				end else begin
					sz_q <= hdr_rd.size;
					bw_q <= '{start: hdr_rd.start, used: 1'b0, size: hdr_rd.size,
						link: hdr_rd.link};
					n_q  <= AW'(fh_n_x);
				end
			end
			btff_pkg::S_FNCHK: begin
				if (nchk) begin
					nw_q   <= hdr_rd;
					tgt_q  <= n_q;
					purp_q <= btff_pkg::W_RM_NEXT;
					cur_q  <= head_q;
					k_q    <= '0;
				end
			end
			btff_pkg::S_NMRG: begin
				sz_q      <= sz_q + nw_q.size;
				bw_q.size <= sz_q + nw_q.size;
			end
			btff_pkg::S_FPCHK: begin
				if (pchk) begin
					psz_q  <= ftr_rd.size;
					p_q    <= b_q - AW'(ftr_rd.size);
					tgt_q  <= b_q - AW'(ftr_rd.size);
					purp_q <= btff_pkg::W_RM_PREV;
					cur_q  <= head_q;
					k_q    <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != btff_pkg::S_IDLE);
	assign done = done_q;

	assign result.status         = status_q;
	assign result.payload_offset = off_q;
	assign result.inuse_bytes    = (32'(bytes_q) > 32'hFFFF) ? 16'hFFFF : 16'(bytes_q);
	assign result.live_blocks    = (32'(live_q) > 32'hFFF) ? 12'hFFF : 12'(live_q);
	assign result.free_blocks    = (32'(fcnt_q) > 32'hFFF) ? 12'hFFF : 12'(fcnt_q);

endmodule

// ===== rtl/btff_checker.sv =====
// port-level checks for the boundary tag allocator, bound to the top level
// depends on btff_pkg and boundary_tag_first_fit_allocator_assert.svh
`timescale 1ns / 1ps
`include "boundary_tag_first_fit_allocator_assert.svh"

module btff_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input btff_pkg::rsp_t result
);

	// an accepted transaction keeps the block busy until its result
	`BTFF_AST_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept did not raise busy")

	`BTFF_AST_NOW(a_done_idle, clk, arst_n, done, !busy, "result while still busy")

	`BTFF_AST_NEXT(a_done_pulse, clk, arst_n, done, !done, "result strobe longer than one cycle")

	// only a successful allocate carries an offset
	`BTFF_AST_NOW(a_fail_no_offset, clk, arst_n, done && (result.status != btff_pkg::ST_OK), result.payload_offset == 16'd0, "offset on a failed transaction")

endmodule

bind boundary_tag_first_fit_allocator btff_checker u_btff_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
